[hdl/mjdr_pkg.sv]
// Shared types and constants for the motor jam detect/reverse block.
// No dependencies; imported by every module under hdl/.
package mjdr_pkg;

  // Widths fixed by the item and register fields
  localparam int SPEED_W    = 8;
  localparam int MINSPD_W   = 7;
  localparam int TICK_W     = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int IN_DATA_W  = 16;  // speed + motor_stopped, padded to bytes
  localparam int OUT_DATA_W = 16;  // drive + jam_active, padded to bytes

  // Default time field width
  localparam int TIME_WIDTH_DEF = 16;

  // Reset value of the tick period register
  localparam logic [TICK_W-1:0] TICK_MS_RST = 8'd10;

  // Full-scale drive magnitude used when reversing out of a jam
  localparam logic signed [SPEED_W-1:0] DRIVE_FULL = 8'sd127;

  // Item kind carried in tuser
  typedef enum logic {
    CMD_SET  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ENABLE     = 3'd0,
    REG_STICK_MODE = 3'd1,
    REG_WAIT_MS    = 3'd2,
    REG_OUTTAKE_MS = 3'd3,
    REG_MIN_SPEED  = 3'd4,
    REG_RETRY_MS   = 3'd5,
    REG_TICK_MS    = 3'd6
  } reg_idx_t;

  // Mode and rate settings handed from the register file to the engine
  typedef struct packed {
    logic                enable;
    logic                stick_mode;
    logic [MINSPD_W-1:0] min_spd;
    logic [TICK_W-1:0]   tick_ms;
  } cfg_ctl_t;

  // Supervisor state visible to the top level
  typedef struct packed {
    logic jammed;
    logic reset_pending;
  } eng_status_t;

endpackage

[hdl/motor_jam_detect_reverse_top.sv]
// Motor jam detect/reverse: input register, supervision engine, result register.
// Input transfers enter the input register; results (if any) go to the result register.
// Throughput: one item per cycle unless out_* stalls; engine state updates once per item.
// Reset: synchronous, active low; clears config and state registers and both valid flags,
// tick period resets to 10 ms. Depends on mjdr_pkg, mjdr_cfg_regs, mjdr_engine.
module motor_jam_detect_reverse_top
  import mjdr_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] speed, [8] motor_stopped
  input  logic                  in_tuser,   // [0] cmd
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] drive, [8] jam_active
  // Configuration
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [TIME_WIDTH-1:0] cfg_wdata
);

  cfg_ctl_t              ctl;
  logic [TIME_WIDTH-1:0] wait_ms;
  logic [TIME_WIDTH-1:0] outtake_ms;
  logic [TIME_WIDTH-1:0] retry_ms;

  logic                      in_v_r;
  cmd_t                      in_cmd_r;
  logic signed [SPEED_W-1:0] in_speed_r;
  logic                      in_stop_r;

  logic                      out_v_r;
  logic signed [SPEED_W-1:0] out_drive_r;
  logic                      out_jam_r;

  logic                      item_go;
  logic                      res_valid;
  logic signed [SPEED_W-1:0] res_drive;
  logic                      res_jam;
  eng_status_t               st;

  mjdr_cfg_regs #(.TIME_WIDTH(TIME_WIDTH)) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .ctl        (ctl),
    .wait_ms    (wait_ms),
    .outtake_ms (outtake_ms),
    .retry_ms   (retry_ms)
  );

  // Item held in the input register is processed when the result slot is free
  assign item_go   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || item_go;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_cmd_r   <= cmd_t'(in_tuser);
      in_speed_r <= $signed(in_tdata[SPEED_W-1:0]);
      in_stop_r  <= in_tdata[SPEED_W];
    end
  end

  mjdr_engine #(.TIME_WIDTH(TIME_WIDTH)) u_eng (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_go      (item_go),
    .item_cmd     (in_cmd_r),
    .item_speed   (in_speed_r),
    .item_stopped (in_stop_r),
    .ctl          (ctl),
    .wait_ms      (wait_ms),
    .outtake_ms   (outtake_ms),
    .retry_ms     (retry_ms),
    .res_valid    (res_valid),
    .res_drive    (res_drive),
    .res_jam      (res_jam),
    .st           (st)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (item_go && res_valid) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_go && res_valid) begin
      out_drive_r <= res_drive;
      out_jam_r   <= res_jam;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_DATA_W-SPEED_W-1){1'b0}}, out_jam_r, out_drive_r};

  // A processed tick always retires the pending reset
  a_tick_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (item_go && in_cmd_r == CMD_TICK) |=> !st.reset_pending)
    else $error("pending reset survived a tick");

  // A tick with a pending reset leaves the block unjammed
  a_pending_unjams: assert property (@(posedge clk) disable iff (!rst_n)
    (item_go && in_cmd_r == CMD_TICK && st.reset_pending) |=> !st.jammed)
    else $error("jam survived a pending reset");

  // A produced result is always captured for delivery
  a_result_captured: assert property (@(posedge clk) disable iff (!rst_n)
    (item_go && res_valid) |=> out_v_r)
    else $error("result lost");

endmodule

[hdl/mjdr_cfg_regs.sv]
// Configuration register file for the motor jam detect/reverse block.
// Depends on mjdr_pkg.
module mjdr_cfg_regs
  import mjdr_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [TIME_WIDTH-1:0] cfg_wdata,
  output cfg_ctl_t              ctl,
  output logic [TIME_WIDTH-1:0] wait_ms,
  output logic [TIME_WIDTH-1:0] outtake_ms,
  output logic [TIME_WIDTH-1:0] retry_ms
);

  cfg_ctl_t              ctl_r;
  logic [TIME_WIDTH-1:0] wait_ms_r;
  logic [TIME_WIDTH-1:0] outtake_ms_r;
  logic [TIME_WIDTH-1:0] retry_ms_r;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.enable     <= 1'b0;
      ctl_r.stick_mode <= 1'b0;
      ctl_r.min_spd    <= '0;
      ctl_r.tick_ms    <= TICK_MS_RST;
      wait_ms_r        <= '0;
      outtake_ms_r     <= '0;
      retry_ms_r       <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_ENABLE:     ctl_r.enable     <= cfg_wdata[0];
        REG_STICK_MODE: ctl_r.stick_mode <= cfg_wdata[0];
        REG_WAIT_MS:    wait_ms_r        <= cfg_wdata;
        REG_OUTTAKE_MS: outtake_ms_r     <= cfg_wdata;
        REG_MIN_SPEED:  ctl_r.min_spd    <= cfg_wdata[MINSPD_W-1:0];
        REG_RETRY_MS:   retry_ms_r       <= cfg_wdata;
        REG_TICK_MS:    ctl_r.tick_ms    <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign ctl        = ctl_r;
  assign wait_ms    = wait_ms_r;
  assign outtake_ms = outtake_ms_r;
  assign retry_ms   = retry_ms_r;

endmodule

[hdl/mjdr_engine.sv]
// Jam supervision engine: speed/jam state registers and the per-item update.
// Depends on mjdr_pkg.
module mjdr_engine
  import mjdr_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       item_go,
  input  cmd_t                       item_cmd,
  input  logic signed [SPEED_W-1:0]  item_speed,
  input  logic                       item_stopped,
  input  cfg_ctl_t                   ctl,
  input  logic [TIME_WIDTH-1:0]      wait_ms,
  input  logic [TIME_WIDTH-1:0]      outtake_ms,
  input  logic [TIME_WIDTH-1:0]      retry_ms,
  output logic                       res_valid,
  output logic signed [SPEED_W-1:0]  res_drive,
  output logic                       res_jam,
  output eng_status_t                st
);

  localparam int CW = TIME_WIDTH + 1;  // elapsed counter width

  logic signed [SPEED_W-1:0] cmd_speed_r, cmd_speed_nxt;
  logic signed [SPEED_W-1:0] prev_speed_r, prev_speed_nxt;
  logic                      jammed_r, jammed_nxt;
  logic [CW-1:0]             elapsed_r, elapsed_nxt;
  logic                      pend_r, pend_nxt;

  logic [SPEED_W-1:0]        mag;
  logic [SPEED_W-1:0]        min_ext;
  logic [CW:0]               sum;
  logic [CW-1:0]             elapsed_sat;
  logic [TIME_WIDTH-1:0]     timeout;
  logic signed [SPEED_W-1:0] jam_drive;

  // Magnitude of the command (-128 gives 128) and widened minimum
  assign mag     = cmd_speed_r[SPEED_W-1] ? (~cmd_speed_r + 8'd1) : cmd_speed_r;
  assign min_ext = {1'b0, ctl.min_spd};

  // Saturating counter advance
  assign sum         = {1'b0, elapsed_r} + (CW+1)'(ctl.tick_ms);
  assign elapsed_sat = sum[CW] ? {CW{1'b1}} : sum[CW-1:0];

  assign timeout = ctl.stick_mode ? retry_ms : outtake_ms;

  // Drive during the jam phase: zero in stick mode or for a zero command, else full reverse
  always_comb begin
    if (ctl.stick_mode || cmd_speed_r == '0) begin
      jam_drive = '0;
    end else if (cmd_speed_r[SPEED_W-1]) begin
      jam_drive = DRIVE_FULL;
    end else begin
      jam_drive = -DRIVE_FULL;
    end
  end

  // Per-item state update and result
  always_comb begin
    cmd_speed_nxt  = cmd_speed_r;
    prev_speed_nxt = prev_speed_r;
    jammed_nxt     = jammed_r;
    elapsed_nxt    = elapsed_r;
    pend_nxt       = pend_r;
    res_valid      = 1'b0;
    res_drive      = '0;
    if (item_cmd == CMD_SET) begin
      cmd_speed_nxt  = item_speed;
      prev_speed_nxt = item_speed;
      if (item_speed != prev_speed_r) begin
        res_drive = item_speed;
        pend_nxt  = 1'b1;
        res_valid = 1'b1;
      end
    end else begin
      if (ctl.enable) begin
        if (jammed_r) begin
          elapsed_nxt = elapsed_sat;
          res_drive   = jam_drive;
          res_valid   = 1'b1;
          if (elapsed_sat > {1'b0, timeout}) begin
            jammed_nxt  = 1'b0;
            elapsed_nxt = '0;
            res_drive   = cmd_speed_r;
          end
        end else if (mag >= min_ext && item_stopped) begin
          elapsed_nxt = elapsed_sat;
          if (elapsed_sat > {1'b0, wait_ms}) begin
            elapsed_nxt = '0;
            jammed_nxt  = 1'b1;
          end
        end
        // Command at or below the minimum speed: elapsed count is cleared
        if (mag <= min_ext) begin
          elapsed_nxt = '0;
        end
      end else begin
        elapsed_nxt = '0;
      end
      // A new set speed cancels any jam at the end of the tick
      if (pend_r) begin
        pend_nxt    = 1'b0;
        jammed_nxt  = 1'b0;
        elapsed_nxt = '0;
      end
    end
    res_jam = jammed_nxt;
  end

  // State registers, updated once per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_speed_r  <= '0;
      prev_speed_r <= '0;
      jammed_r     <= 1'b0;
      elapsed_r    <= '0;
      pend_r       <= 1'b0;
    end else if (item_go) begin
      cmd_speed_r  <= cmd_speed_nxt;
      prev_speed_r <= prev_speed_nxt;
      jammed_r     <= jammed_nxt;
      elapsed_r    <= elapsed_nxt;
      pend_r       <= pend_nxt;
    end
  end

  assign st.jammed        = jammed_r;
  assign st.reset_pending = pend_r;

endmodule
